[hw/rtl/f2r_pkg.sv]
package f2r_pkg;

  // Integer-magnitude limits that choose the scale.
  localparam logic [31:0] LIMIT_SCALE1   = 32'd21474836;
  localparam logic [31:0] LIMIT_SCALE100 = 32'd214748;
  localparam logic [31:0] LIMIT_SCALE10K = 32'd2147;
  localparam logic [63:0] MAG_MAX        = 64'd2147483647;

  // Exact division by five: multiply by the inverse of 5 modulo 2^32.
  localparam logic [31:0] INV5      = 32'hCCCCCCCD;
  localparam logic [31:0] DIV5_MAXQ = 32'd858993459;

  // Number of reduction stages; each can remove one factor of 2 and one of 5.
  localparam int unsigned NUM_RED = 6;

  typedef enum logic [1:0] {
    SC_ONE,
    SC_HUND,
    SC_TENK,
    SC_MILL
  } scale_e;

  // Data carried through the reduction stages.
  typedef struct packed {
    logic        valid;
    logic        neg;
    logic        spec;
    logic        sat;
    logic [30:0] mag;
    logic [2:0]  k2;
    logic [2:0]  k5;
  } stage_t;

  function automatic logic [19:0] scale_val(scale_e sc);
    logic [19:0] v;
    unique case (sc)
      SC_ONE:  v = 20'd1;
      SC_HUND: v = 20'd100;
      SC_TENK: v = 20'd10000;
      default: v = 20'd1000000;
    endcase
    return v;
  endfunction

  // Power of ten of the scale, which is also its power of two and of five.
  function automatic logic [2:0] scale_exp(scale_e sc);
    logic [2:0] v;
    unique case (sc)
      SC_ONE:  v = 3'd0;
      SC_HUND: v = 3'd2;
      SC_TENK: v = 3'd4;
      default: v = 3'd6;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] pow2(logic [2:0] k);
    return 7'(7'd1 << k);
  endfunction

  function automatic logic [13:0] pow5(logic [2:0] k);
    logic [13:0] v;
    case (k)
      3'd0:    v = 14'd1;
      3'd1:    v = 14'd5;
      3'd2:    v = 14'd25;
      3'd3:    v = 14'd125;
      3'd4:    v = 14'd625;
      3'd5:    v = 14'd3125;
      default: v = 14'd15625;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/f2r_in_if.sv]
interface f2r_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink (input valid, input float_bits, output ready);
endinterface

[hw/rtl/f2r_out_if.sv]
interface f2r_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] numerator;
  logic        [19:0] denominator;
  logic               saturated;

  modport source (output valid, output numerator, output denominator, output saturated,
                  input ready);
  modport sink (input valid, input numerator, input denominator, input saturated,
                output ready);
endinterface

[hw/rtl/f2r_reduce_stage.sv]
module f2r_reduce_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  f2r_pkg::stage_t stage_i,
  output f2r_pkg::stage_t stage_o
);

  f2r_pkg::stage_t stage_d, data_q;
  logic        valid_q;
  logic [30:0] mag2;
  logic [2:0]  k2_n;
  logic [63:0] prod;
  logic [31:0] quot;

  // Remove one factor of two, then try one exact division by five.
  always_comb begin
    stage_d = stage_i;
    mag2    = stage_i.mag;
    k2_n    = stage_i.k2;
    if (stage_i.k2 != 3'd0 && !stage_i.mag[0]) begin
      mag2 = {1'b0, stage_i.mag[30:1]};
      k2_n = stage_i.k2 - 3'd1;
    end
    prod = {33'd0, mag2} * {32'd0, f2r_pkg::INV5};
    quot = prod[31:0];
    stage_d.mag = mag2;
    stage_d.k2  = k2_n;
    if (stage_i.k5 != 3'd0 && quot <= f2r_pkg::DIV5_MAXQ) begin
      stage_d.mag = quot[30:0];
      stage_d.k5  = stage_i.k5 - 3'd1;
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule

[hw/rtl/float_to_rational_converter_core.sv]
// Float to rational converter.
// A request on in_i carries one binary32 word (float_bits). For each request
// one result leaves on out_o: a reduced signed numerator, a denominator of up
// to 1000000 (zero for NaN, infinity or magnitudes at or above 2^31) and a
// saturation flag for scaled values clamped to +/-2147483647.
// The block is a ten-stage pipeline: decode and scale choice, the 24 x 20
// bit scaling multiply, rounding shift and clamp, six reduction stages that
// each strip one factor of two and one factor of five, and the output
// register. One request is accepted in every cycle unless a result waits
// on out_o with ready low.
// The whole pipeline advances together: while a result waits on out_o with
// ready low, every stage holds and in_i.ready is low, so nothing is lost or
// repeated. Stages that hold bubbles advance as soon as out_o is free.
// Reset clears all valid bits; the data registers are not reset.
module float_to_rational_converter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  f2r_in_if.sink    in_i,
  f2r_out_if.source out_o
);

  logic adv;

  // Global advance: the pipeline moves when the output register can take data.
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: decode the word and choose the scale.
  logic              neg_c, nan_c, big_c;
  logic [7:0]        expf_c;
  logic [22:0]       frac_c;
  logic [23:0]       sig_c;
  logic signed [8:0] e_c;
  logic [8:0]        s_c;
  logic [31:0]       ipart_c;
  f2r_pkg::scale_e   sc_c;

  always_comb begin
    neg_c  = in_i.float_bits[31];
    expf_c = in_i.float_bits[30:23];
    frac_c = in_i.float_bits[22:0];
    nan_c  = (expf_c == 8'hFF) && (frac_c != 23'd0);
    big_c  = (expf_c >= 8'd158);
    if (expf_c == 8'd0) begin
      sig_c = {1'b0, frac_c};
      e_c   = -9'sd149;
    end else begin
      sig_c = {1'b1, frac_c};
      e_c   = $signed({1'b0, expf_c}) - 9'sd150;
    end
    s_c = 9'(-e_c);
    if (!e_c[8]) begin
      ipart_c = 32'({8'd0, sig_c} << e_c[2:0]);
    end else if (s_c >= 9'd32) begin
      ipart_c = 32'd0;
    end else begin
      ipart_c = {8'd0, sig_c} >> s_c[4:0];
    end
    if (ipart_c > f2r_pkg::LIMIT_SCALE1) begin
      sc_c = f2r_pkg::SC_ONE;
    end else if (ipart_c > f2r_pkg::LIMIT_SCALE100) begin
      sc_c = f2r_pkg::SC_HUND;
    end else if (ipart_c > f2r_pkg::LIMIT_SCALE10K) begin
      sc_c = f2r_pkg::SC_TENK;
    end else begin
      sc_c = f2r_pkg::SC_MILL;
    end
  end

  logic              p1_v_q, p1_neg_q, p1_nan_q, p1_big_q;
  logic [23:0]       p1_sig_q;
  logic signed [8:0] p1_e_q;
  f2r_pkg::scale_e   p1_sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_neg_q <= neg_c;
      p1_nan_q <= nan_c;
      p1_big_q <= big_c;
      p1_sig_q <= sig_c;
      p1_e_q   <= e_c;
      p1_sc_q  <= sc_c;
    end
  end

  // Stage 2: exact product of significand and scale.
  logic              p2_v_q, p2_neg_q, p2_nan_q, p2_big_q;
  logic [43:0]       p2_prod_q;
  logic signed [8:0] p2_e_q;
  f2r_pkg::scale_e   p2_sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (adv) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_neg_q  <= p1_neg_q;
      p2_nan_q  <= p1_nan_q;
      p2_big_q  <= p1_big_q;
      p2_prod_q <= {20'd0, p1_sig_q} * {24'd0, f2r_pkg::scale_val(p1_sc_q)};
      p2_e_q    <= p1_e_q;
      p2_sc_q   <= p1_sc_q;
    end
  end

  // Stage 3: shift by the exponent with rounding half away from zero, clamp.
  logic [63:0]     prod64, rmag;
  logic [8:0]      s3;
  logic            sat3;
  f2r_pkg::stage_t st3;

  always_comb begin
    prod64 = {20'd0, p2_prod_q};
    s3     = 9'(-p2_e_q);
    if (!p2_e_q[8]) begin
      rmag = prod64 << p2_e_q[2:0];
    end else if (s3 > 9'd62) begin
      rmag = 64'd0;
    end else begin
      rmag = (prod64 + (64'd1 << (s3[5:0] - 6'd1))) >> s3[5:0];
    end
    sat3 = rmag > f2r_pkg::MAG_MAX;

    st3.valid = p2_v_q;
    st3.neg   = p2_neg_q;
    st3.spec  = 1'b0;
    st3.sat   = sat3;
    st3.mag   = sat3 ? 31'h7FFFFFFF : rmag[30:0];
    st3.k2    = f2r_pkg::scale_exp(p2_sc_q);
    st3.k5    = f2r_pkg::scale_exp(p2_sc_q);
    if (p2_nan_q || p2_big_q) begin
      // Not representable: plus or minus one over zero, NaN negative.
      st3.neg  = p2_nan_q || p2_neg_q;
      st3.spec = 1'b1;
      st3.sat  = 1'b0;
      st3.mag  = 31'd1;
      st3.k2   = 3'd0;
      st3.k5   = 3'd0;
    end else if (!sat3 && rmag[30:0] == 31'd0) begin
      // Zero reduces to zero over one.
      st3.neg = 1'b0;
      st3.k2  = 3'd0;
      st3.k5  = 3'd0;
    end
  end

  f2r_pkg::stage_t p3_q, p3_data_q;
  logic            p3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (adv) begin
      p3_v_q <= st3.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_data_q <= st3;
    end
  end

  always_comb begin
    p3_q       = p3_data_q;
    p3_q.valid = p3_v_q;
  end

  // Reduction stages: divide out common factors of two and five.
  f2r_pkg::stage_t red [f2r_pkg::NUM_RED+1];

  assign red[0] = p3_q;

  for (genvar gi = 0; gi < f2r_pkg::NUM_RED; gi++) begin : g_red
    f2r_reduce_stage u_red (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (red[gi]),
      .stage_o (red[gi+1])
    );
  end

  // Output register: apply the sign and rebuild the reduced denominator.
  f2r_pkg::stage_t    fin;
  logic               out_v_q, out_sat_q;
  logic signed [31:0] out_num_q;
  logic        [19:0] out_den_q;

  assign fin = red[f2r_pkg::NUM_RED];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_num_q <= fin.neg ? -$signed({1'b0, fin.mag}) : $signed({1'b0, fin.mag});
      out_den_q <= fin.spec ? 20'd0
                            : 20'({13'd0, f2r_pkg::pow2(fin.k2)} * {6'd0, f2r_pkg::pow5(fin.k5)});
      out_sat_q <= fin.sat;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.numerator   = out_num_q;
  assign out_o.denominator = out_den_q;
  assign out_o.saturated   = out_sat_q;

  // A zero denominator only ever comes with a numerator of plus or minus one.
  a_spec_num : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.denominator == 20'd0 |->
      (out_o.numerator == 32'sd1 || out_o.numerator == -32'sd1) && !out_o.saturated)
    else $error("special result with bad numerator");

  // A clamped result is the largest magnitude over a nonzero scale.
  a_sat_val : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_o.numerator == 32'sd2147483647 || out_o.numerator == -32'sd2147483647)
      && out_o.denominator != 20'd0)
    else $error("saturated result not clamped");

  // A zero numerator is always reduced to a denominator of one.
  a_zero_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.numerator == 32'sd0 |-> out_o.denominator == 20'd1)
    else $error("zero not reduced");

endmodule

[tb/sv/f2r_scoreboard.sv]
// Rational approximation predictor and result checker.
class f2r_scoreboard;
  typedef struct {
    logic [31:0] num;
    logic [19:0] den;
    logic        sat;
    logic [31:0] bits;
  } frac_t;

  frac_t pending_q[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Euclid on 32-bit magnitudes.
  static function automatic logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Work out the reduced fraction of one binary32 word.
  static function automatic frac_t convert(logic [31:0] bits);
    frac_t r;
    logic neg;
    logic [7:0] ex;
    logic [22:0] fr;
    logic [63:0] sig, ipart, prod, rmag;
    int e;
    int unsigned s;
    logic [31:0] scale, mag, g;
    neg = bits[31];
    ex = bits[30:23];
    fr = bits[22:0];
    r.bits = bits;
    r.sat = 1'b0;
    if (ex == 8'hFF && fr != 0) begin
      r.num = -32'sd1;
      r.den = 0;
      return r;
    end
    if (ex >= 8'd158) begin
      r.num = neg ? -32'sd1 : 32'sd1;
      r.den = 0;
      return r;
    end
    if (ex == 0) begin
      sig = {41'd0, fr};
      e = -149;
    end else begin
      sig = {40'd0, 1'b1, fr};
      e = int'(ex) - 150;
    end
    if (e >= 0) ipart = sig << e;
    else begin
      s = -e;
      ipart = (s >= 32) ? 64'd0 : (sig >> s);
    end
    if (ipart > f2r_pkg::LIMIT_SCALE1) scale = 1;
    else if (ipart > f2r_pkg::LIMIT_SCALE100) scale = 100;
    else if (ipart > f2r_pkg::LIMIT_SCALE10K) scale = 10000;
    else scale = 1000000;
    prod = sig * scale;
    if (e >= 0) rmag = prod << e;
    else begin
      s = -e;
      rmag = (s > 62) ? 64'd0 : ((prod + (64'd1 << (s - 1))) >> s);
    end
    if (rmag > f2r_pkg::MAG_MAX) begin
      mag = 32'h7FFFFFFF;
      r.sat = 1'b1;
    end else mag = rmag[31:0];
    g = gcd32(mag, scale);
    r.num = (neg && mag != 0) ? -(mag / g) : (mag / g);
    r.den = 20'(scale / g);
    return r;
  endfunction

  function void note_request(logic [31:0] bits);
    pending_q.push_back(convert(bits));
  endfunction

  function void check_result(logic [31:0] num, logic [19:0] den, logic sat);
    frac_t x;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result num=%0d den=%0d", $signed(num), den);
      return;
    end
    x = pending_q.pop_front();
    if (num !== x.num || den !== x.den || sat !== x.sat) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in=%h exp %0d/%0d sat %b got %0d/%0d sat %b", x.bits,
                 $signed(x.num), x.den, x.sat, $signed(num), den, sat);
    end
  endfunction
endclass

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  f2r_in_if in_if ();
  f2r_out_if out_if ();

  float_to_rational_converter_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  f2r_scoreboard frac_sb = new();
  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 87;
  int unsigned hold_cycles = 0;
  longint unsigned cycle_cnt = 0;
  bit timed_out = 1'b0;

  initial begin
    in_if.valid = 1'b0;
    in_if.float_bits = '0;
    out_if.ready = 1'b0;
  end

  // Count cycles and stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000 && !timed_out) begin
      timed_out = 1'b1;
      $display("[float_to_rational_converter_core] ERROR");
      $finish;
    end
  end

  // Receiver: checks each accepted result; random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      frac_sb.check_result(out_if.numerator, out_if.denominator, out_if.saturated);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one word and wait until it is accepted; valid stays up for the next word.
  task automatic send_word(logic [31:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.float_bits <= bits;
    do @(posedge clk_i); while (!in_if.ready);
    frac_sb.note_request(bits);
  endtask

  // Random word biased toward interesting exponent ranges.
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(5))
      0: w[30:23] = 8'($urandom_range(100, 160));
      1: w[30:23] = 8'($urandom_range(134, 157));
      2: w[30:23] = 8'($urandom_range(0, 3));
      3: w[30:23] = 8'($urandom_range(118, 140));
      default: ;
    endcase
    return w;
  endfunction

  logic [31:0] directed_q[$] = '{
    32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
    32'hFFFFFFFF, 32'h7F800001, 32'h4F000000, 32'hCF000000, 32'h4EFFFFFF,
    32'hCEFFFFFF, 32'h00000001, 32'h007FFFFF, 32'h3F800000, 32'hBF000000,
    32'h3F2AAAAB, 32'h4B23D70A, 32'h4B23D70B, 32'h4851B300, 32'h45063000,
    32'h45062000, 32'h33000000, 32'h32FFFFFF, 32'h5555AAAA, 32'hAAAA5555
  };

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_q[i]) send_word(directed_q[i]);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 87;
        recv_idle_pct = 24;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 60;
      end
      for (int n = 0; n < 333; n++) send_word(rand_word());
    end
    in_if.valid <= 1'b0;
    while (frac_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (frac_sb.mismatches == 0 && frac_sb.pending_q.size() == 0)
      $display("[float_to_rational_converter_core] OK");
    else
      $display("[float_to_rational_converter_core] ERROR");
    $finish;
  end
endmodule
